// ===== src/esd_pkg.sv =====
// Shared types, character codes and helpers for the escape sequence decoder.
package esd_pkg;

   localparam logic [7:0] BACKSLASH_CHAR       = 8'h5C;
   localparam logic [7:0] LOWER_N_CHAR         = 8'h6E;
   localparam logic [7:0] LOWER_R_CHAR         = 8'h72;
   localparam logic [7:0] LOWER_T_CHAR         = 8'h74;
   localparam logic [7:0] LOWER_X_CHAR         = 8'h78;
   localparam logic [7:0] LINE_FEED_BYTE       = 8'h0A;
   localparam logic [7:0] CARRIAGE_RETURN_BYTE = 8'h0D;
   localparam logic [7:0] TAB_BYTE             = 8'h09;

   localparam int unsigned MAX_BYTES = 4;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_SLASH = 2'd1,
      PHASE_X     = 2'd2,
      PHASE_HEX   = 2'd3
   } phase_type;

   // Up to four decoded bytes produced by one input transaction.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [1:0]                last_idx;
      logic                      last;
   } bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      hex_value = v[3:0];
   endfunction

endpackage

// ===== src/esd_chan_if.sv =====
// Valid/ready channel interfaces for the decoder's input and result streams.
interface esd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;
   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface esd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/esd_front.sv =====
// Front end: escape phase tracking and per-character byte bundle generation.
module esd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_char,
   input  logic                in_last,
   output logic                push_valid,
   output esd_pkg::bundle_type push_data
);

   esd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         first_hex_ff, first_hex_in;
   logic               idle_emit;
   logic               hex_ok;
   logic [2:0]         count;

   // A character seen with nothing pending goes out unless it opens an escape.
   assign idle_emit = !(in_char == esd_pkg::BACKSLASH_CHAR && !in_last);
   assign hex_ok    = esd_pkg::is_hex(in_char);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= esd_pkg::PHASE_IDLE;
         first_hex_ff <= 8'h00;
      end else if (accept) begin
         phase_ff     <= phase_in;
         first_hex_ff <= first_hex_in;
      end
   end

   // Next phase
   always_comb begin
      phase_in     = idle_emit ? esd_pkg::PHASE_IDLE : esd_pkg::PHASE_SLASH;
      first_hex_in = first_hex_ff;
      unique case (phase_ff)
         esd_pkg::PHASE_IDLE: begin
         end
         esd_pkg::PHASE_SLASH: begin
            if (in_char == esd_pkg::LOWER_X_CHAR && !in_last) begin
               phase_in = esd_pkg::PHASE_X;
            end else if (in_char == esd_pkg::BACKSLASH_CHAR ||
                         in_char == esd_pkg::LOWER_N_CHAR ||
                         in_char == esd_pkg::LOWER_R_CHAR ||
                         in_char == esd_pkg::LOWER_T_CHAR) begin
               phase_in = esd_pkg::PHASE_IDLE;
            end
         end
         esd_pkg::PHASE_X: begin
            if (hex_ok && !in_last) begin
               phase_in     = esd_pkg::PHASE_HEX;
               first_hex_in = in_char;
            end
         end
         esd_pkg::PHASE_HEX: begin
            if (hex_ok) begin
               phase_in = esd_pkg::PHASE_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   // Output bundle
   always_comb begin
      push_data.bytes = '0;
      count           = 3'd0;
      unique case (phase_ff)
         esd_pkg::PHASE_IDLE: begin
            push_data.bytes[0] = in_char;
            count              = idle_emit ? 3'd1 : 3'd0;
         end
         esd_pkg::PHASE_SLASH: begin
            count = 3'd1;
            if (in_char == esd_pkg::BACKSLASH_CHAR) begin
               push_data.bytes[0] = esd_pkg::BACKSLASH_CHAR;
            end else if (in_char == esd_pkg::LOWER_N_CHAR) begin
               push_data.bytes[0] = esd_pkg::LINE_FEED_BYTE;
            end else if (in_char == esd_pkg::LOWER_R_CHAR) begin
               push_data.bytes[0] = esd_pkg::CARRIAGE_RETURN_BYTE;
            end else if (in_char == esd_pkg::LOWER_T_CHAR) begin
               push_data.bytes[0] = esd_pkg::TAB_BYTE;
            end else if (in_char == esd_pkg::LOWER_X_CHAR && !in_last) begin
               count = 3'd0;
            end else begin
               // unknown escape: backslash, then the character as plain input
               push_data.bytes[0] = esd_pkg::BACKSLASH_CHAR;
               push_data.bytes[1] = in_char;
               count              = idle_emit ? 3'd2 : 3'd1;
            end
         end
         esd_pkg::PHASE_X: begin
            if (!(hex_ok && !in_last)) begin
               push_data.bytes[0] = esd_pkg::BACKSLASH_CHAR;
               push_data.bytes[1] = esd_pkg::LOWER_X_CHAR;
               push_data.bytes[2] = in_char;
               count              = idle_emit ? 3'd3 : 3'd2;
            end
         end
         esd_pkg::PHASE_HEX: begin
            if (hex_ok) begin
               push_data.bytes[0] = {esd_pkg::hex_value(first_hex_ff),
                                     esd_pkg::hex_value(in_char)};
               count              = 3'd1;
            end else begin
               push_data.bytes[0] = esd_pkg::BACKSLASH_CHAR;
               push_data.bytes[1] = esd_pkg::LOWER_X_CHAR;
               push_data.bytes[2] = first_hex_ff;
               push_data.bytes[3] = in_char;
               count              = idle_emit ? 3'd4 : 3'd3;
            end
         end
         default: begin
         end
      endcase
   end

   assign push_data.last_idx = 2'(count - 3'd1);
   assign push_data.last     = in_last;
   assign push_valid         = accept && (count != 3'd0);

endmodule

// ===== src/esd_queue.sv =====
// Small bundle queue decoupling the front end from the byte serializer.
module esd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  esd_pkg::bundle_type       push_data,
   input  logic                      pop,
   output esd_pkg::bundle_type       pop_data,
   output logic                      full,
   output logic                      empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   esd_pkg::bundle_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// ===== src/esd_back.sv =====
// Back end: serializes queued bundles into single-byte result transactions.
module esd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  esd_pkg::bundle_type q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          out_byte,
   output logic                out_last
);

   esd_pkg::bundle_type cur_ff, cur_in;
   logic [1:0]          idx_ff, idx_in;
   logic                busy_ff, busy_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                last_ff, last_in;
   logic                out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (out_free) begin
         if (busy_ff) begin
            valid_in = 1'b1;
            byte_in  = cur_ff.bytes[idx_ff];
            last_in  = cur_ff.last && (idx_ff == cur_ff.last_idx);
            busy_in  = (idx_ff != cur_ff.last_idx);
            idx_in   = idx_ff + 2'd1;
         end else if (!q_empty) begin
            // first byte goes straight out; the rest of the bundle is parked
            q_pop    = 1'b1;
            valid_in = 1'b1;
            byte_in  = q_data.bytes[0];
            last_in  = q_data.last && (q_data.last_idx == 2'd0);
            if (q_data.last_idx != 2'd0) begin
               cur_in  = q_data;
               idx_in  = 2'd1;
               busy_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// ===== src/escape_sequence_decoder_unit.sv =====
// Top level of the C-style escape sequence decoder.
//
//  channel    dir  payload                 transaction
//  req_chan   in   in_char[7:0], in_last   one input character
//  rsp_chan   out  out_byte[7:0], out_last one decoded byte
//
//  One character is taken per cycle while the bundle queue has room.
//  Each character yields 0..4 bytes; the serializer sends one byte per
//  cycle while the result channel is ready.
//  First byte of a bundle leaves through the bundle queue and then the output register.
//  Synchronous active-high reset clears phase, queue and output valid.
//  Output stalls fill the queue; req ready drops only when it is full.
module escape_sequence_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   esd_req_if.sink  req_chan,
   esd_rsp_if.source rsp_chan
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   logic                req_accept;
   logic                push_valid;
   esd_pkg::bundle_type push_data;
   esd_pkg::bundle_type pop_data;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   logic [CNT_W-1:0]    q_count;

   // Accept whenever the queue can take a worst-case bundle.
   assign req_chan.ready = !q_full;
   assign req_accept     = req_chan.valid && !q_full;

   // Front end: escape state and byte bundle per character.
   esd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .in_char    (req_chan.in_char),
      .in_last    (req_chan.in_last),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Queue of bundles; empty bundles (held characters) are never pushed.
   esd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty),
      .count     (q_count)
   );

   // Back end: one byte per result transaction through an output register.
   esd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .out_last  (rsp_chan.out_last)
   );

`ifndef NO_ASSERTIONS
   // Queue occupancy never exceeds its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("bundle queue overflow");

   // Serializer only pops a non-empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_count != '0))
      else $error("pop from empty bundle queue");

   // No result is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the escape sequence decoder unit.
`timescale 1ns / 1ps

module tb_top;

   localparam int LONG_HOLD_CYCLES = 80;
   localparam int RANDOM_ITEM_GOAL = 180;   // directed plus random transactions
   localparam int TAIL_CYCLES      = 6;     // covers the output register and queue drain
   localparam int ERRORS_SHOWN     = 10;

   // One decoded byte as seen on the result channel.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } dec_byte_type;

   // One input transaction, optionally carrying its expected bytes typed in by hand.
   typedef struct packed {
      logic [7:0]      ch;
      logic            last;
      logic            typed;
      logic [2:0]      n_bytes;
      logic [3:0][7:0] bytes;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   esd_req_if req_bus ();
   esd_rsp_if rsp_bus ();

   escape_sequence_decoder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state and queues
   // ------------------------------------------------------------------
   esd_pkg::phase_type decode_phase = esd_pkg::PHASE_IDLE;
   logic [7:0]         held_digit   = 8'h00;
   dec_byte_type       step_bytes[$];       // bytes produced by the current transaction
   dec_byte_type       expected_bytes[$];   // bytes still owed by the DUT, oldest first
   stim_type           offered_rows[$];     // transactions offered, awaiting acceptance
   int                 error_count = 0;
   int                 items_sent  = 0;

   // Handshake between stimulus and the receiver for the long hold-off.
   int          long_hold_req  = 0;
   int          long_holds_done = 0;

   // Sender burst bookkeeping.
   int          burst_left   = 4;
   int          gapless_left = 0;

   function automatic logic hex_digit_ok(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;   // fold A-F onto a-f; nothing else lands in a-f
      return (c inside {[8'h30:8'h39]}) || (folded inside {[8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] digit_nibble(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c <= 8'h39) begin
         return c[3:0];
      end
      return 4'(folded - 8'h57);   // 'a' -> 10
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      if (step_bytes.size() < esd_pkg::MAX_BYTES) begin
         step_bytes.push_back('{data: b, last: 1'b0});
      end
   endfunction

   // Character with no escape pending: a backslash is held unless it ends the string.
   function automatic void plain_char(input logic [7:0] c, input logic l);
      if (c == esd_pkg::BACKSLASH_CHAR && !l) begin
         decode_phase = esd_pkg::PHASE_SLASH;
      end else begin
         emit_byte(c);
         decode_phase = esd_pkg::PHASE_IDLE;
      end
   endfunction

   // Advance the predictor by one character; results land in step_bytes.
   function automatic void decode_step(input logic [7:0] c, input logic l);
      step_bytes.delete();
      case (decode_phase)
         esd_pkg::PHASE_IDLE: begin
            plain_char(c, l);
         end
         esd_pkg::PHASE_SLASH: begin
            decode_phase = esd_pkg::PHASE_IDLE;
            if (c == esd_pkg::BACKSLASH_CHAR) begin
               emit_byte(esd_pkg::BACKSLASH_CHAR);
            end else if (c == esd_pkg::LOWER_N_CHAR) begin
               emit_byte(esd_pkg::LINE_FEED_BYTE);
            end else if (c == esd_pkg::LOWER_R_CHAR) begin
               emit_byte(esd_pkg::CARRIAGE_RETURN_BYTE);
            end else if (c == esd_pkg::LOWER_T_CHAR) begin
               emit_byte(esd_pkg::TAB_BYTE);
            end else if (c == esd_pkg::LOWER_X_CHAR && !l) begin
               decode_phase = esd_pkg::PHASE_X;
            end else begin
               // unknown or cut-off escape: backslash goes out, char is reprocessed
               emit_byte(esd_pkg::BACKSLASH_CHAR);
               plain_char(c, l);
            end
         end
         esd_pkg::PHASE_X: begin
            if (hex_digit_ok(c) && !l) begin
               held_digit   = c;
               decode_phase = esd_pkg::PHASE_HEX;
            end else begin
               emit_byte(esd_pkg::BACKSLASH_CHAR);
               emit_byte(esd_pkg::LOWER_X_CHAR);
               plain_char(c, l);
            end
         end
         default: begin
            if (hex_digit_ok(c)) begin
               emit_byte({digit_nibble(held_digit), digit_nibble(c)});
               decode_phase = esd_pkg::PHASE_IDLE;
            end else begin
               emit_byte(esd_pkg::BACKSLASH_CHAR);
               emit_byte(esd_pkg::LOWER_X_CHAR);
               emit_byte(held_digit);
               plain_char(c, l);
            end
         end
      endcase
      // end of string flushes everything; the final byte carries the flag
      if (l) begin
         decode_phase = esd_pkg::PHASE_IDLE;
         if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size()-1].last = 1'b1;
         end
      end
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= ERRORS_SHOWN) begin
         $display("%s", msg);
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: predict on every input transaction, check every result
   // ------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      stim_type     row_info;
      dec_byte_type got;
      dec_byte_type want;
      if (reset) begin
         decode_phase = esd_pkg::PHASE_IDLE;
         held_digit   = 8'h00;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            row_info = offered_rows.pop_front();
            decode_step(req_bus.in_char, req_bus.in_last);
            if (row_info.typed) begin
               // hand-typed expectation replaces the predicted one for this row
               for (int k = 0; k < int'(row_info.n_bytes); k++) begin
                  expected_bytes.push_back('{data: row_info.bytes[k],
                     last: row_info.last && (k == int'(row_info.n_bytes) - 1)});
               end
            end else begin
               foreach (step_bytes[k]) begin
                  expected_bytes.push_back(step_bytes[k]);
               end
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{data: rsp_bus.out_byte, last: rsp_bus.out_last};
            if (expected_bytes.size() == 0) begin
               log_error($sformatf("unexpected result: byte %h last %b", got.data, got.last));
            end else begin
               want = expected_bytes.pop_front();
               if (got.data !== want.data || got.last !== want.last) begin
                  log_error($sformatf("mismatch: byte exp %h act %h, last exp %b act %b",
                                      want.data, got.data, want.last, got.last));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall patterns of its own, plus a long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int mode;
      int span;
      int tick;
      rsp_bus.ready <= 1'b0;
      tick = 0;
      forever begin
         mode = $urandom_range(0, 4);
         span = $urandom_range(10, 60);
         repeat (span) begin
            if (long_hold_req != long_holds_done) begin
               // hold off long enough for the bundle queue to fill and stall the input
               for (int k = 0; k < LONG_HOLD_CYCLES; k++) begin
                  rsp_bus.ready <= 1'b0;
                  @(posedge clock);
               end
               long_holds_done++;
            end
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               3: rsp_bus.ready <= (tick % 3 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   function automatic stim_type stim_row(input logic [7:0] c, input logic l, input logic t,
                                         input int n, input logic [7:0] b0 = 8'h00,
                                         input logic [7:0] b1 = 8'h00,
                                         input logic [7:0] b2 = 8'h00,
                                         input logic [7:0] b3 = 8'h00);
      stim_type r;
      r.ch       = c;
      r.last     = l;
      r.typed    = t;
      r.n_bytes  = 3'(n);
      r.bytes[0] = b0;
      r.bytes[1] = b1;
      r.bytes[2] = b2;
      r.bytes[3] = b3;
      return r;
   endfunction

   task automatic idle_cycles(input int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Offer one transaction, wait for acceptance, then maybe open a gap.
   task automatic send_item(input stim_type r);
      int gap;
      offered_rows.push_back(r);
      req_bus.valid   <= 1'b1;
      req_bus.in_char <= r.ch;
      req_bus.in_last <= r.last;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (gapless_left > 0) begin
         gapless_left--;
      end else begin
         burst_left--;
         if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               idle_cycles(gap);
            end
            burst_left = $urandom_range(1, 16);
         end
      end
   endtask

   // Stop offering until every expected byte has come back, then let the pipe settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0 || offered_rows.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) begin
         return 8'(8'h30 + v);
      end else if (v < 16) begin
         return 8'(8'h61 + v - 10);
      end
      return 8'(8'h41 + v - 16);
   endfunction

   initial begin : stimulus
      stim_type   directed[$];
      logic [7:0] text[$];
      int         n_seg;
      int         string_idx;
      logic [7:0] simple_codes[4];
      req_bus.valid   <= 1'b0;
      req_bus.in_char <= 8'h00;
      req_bus.in_last <= 1'b0;
      simple_codes = '{esd_pkg::BACKSLASH_CHAR, esd_pkg::LOWER_N_CHAR,
                       esd_pkg::LOWER_R_CHAR, esd_pkg::LOWER_T_CHAR};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table: char, last, typed, count, expected bytes
      directed.push_back(stim_row(8'h00, 1'b0, 1'b1, 1, 8'h00));
      directed.push_back(stim_row(8'hFF, 1'b0, 1'b1, 1, 8'hFF));
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));        // held
      directed.push_back(stim_row(esd_pkg::LOWER_N_CHAR, 1'b0, 1'b1, 1,
                                  esd_pkg::LINE_FEED_BYTE));
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(esd_pkg::LOWER_R_CHAR, 1'b0, 1'b1, 1,
                                  esd_pkg::CARRIAGE_RETURN_BYTE));
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(esd_pkg::LOWER_T_CHAR, 1'b0, 1'b1, 1, esd_pkg::TAB_BYTE));
      // unknown escape: backslash and 'q' both pass through
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(8'h71, 1'b0, 1'b1, 2, esd_pkg::BACKSLASH_CHAR, 8'h71));
      // hex escape, mixed case: \xaF
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(esd_pkg::LOWER_X_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(8'h61, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(8'h46, 1'b0, 1'b0, 0));
      // bad first hex digit 'g'
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(esd_pkg::LOWER_X_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(8'h67, 1'b0, 1'b1, 3, esd_pkg::BACKSLASH_CHAR,
                                  esd_pkg::LOWER_X_CHAR, 8'h67));
      // \\ escape finishing the string, then a lone backslash as a whole string
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b1, 1'b1, 1,
                                  esd_pkg::BACKSLASH_CHAR));
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b1, 1'b1, 1,
                                  esd_pkg::BACKSLASH_CHAR));
      // \x cut off by end of string
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(esd_pkg::LOWER_X_CHAR, 1'b1, 1'b1, 2,
                                  esd_pkg::BACKSLASH_CHAR, esd_pkg::LOWER_X_CHAR));
      // \x9 followed by non-hex on the last char: full four-byte flush
      directed.push_back(stim_row(esd_pkg::BACKSLASH_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(esd_pkg::LOWER_X_CHAR, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(8'h39, 1'b0, 1'b1, 0));
      directed.push_back(stim_row(8'h5A, 1'b1, 1'b1, 4,
                                  esd_pkg::BACKSLASH_CHAR, esd_pkg::LOWER_X_CHAR,
                                  8'h39, 8'h5A));

      foreach (directed[i]) begin
         send_item(directed[i]);
      end
      drain_results();

      // Random strings: plain characters and well-formed escapes with noise and broken ones mixed in
      string_idx = 0;
      while (items_sent < RANDOM_ITEM_GOAL) begin
         text.delete();
         n_seg = $urandom_range(1, 5);
         repeat (n_seg) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  text.push_back(8'($urandom_range(0, 255)));
               end
               3: begin
                  text.push_back(esd_pkg::BACKSLASH_CHAR);
                  text.push_back(simple_codes[$urandom_range(0, 3)]);
               end
               4, 5: begin
                  text.push_back(esd_pkg::BACKSLASH_CHAR);
                  text.push_back(esd_pkg::LOWER_X_CHAR);
                  text.push_back(rand_hex_char());
                  text.push_back(rand_hex_char());
               end
               6: begin
                  text.push_back(esd_pkg::BACKSLASH_CHAR);
                  text.push_back(8'($urandom_range(0, 255)));
               end
               7: begin
                  text.push_back(esd_pkg::BACKSLASH_CHAR);
                  text.push_back(esd_pkg::LOWER_X_CHAR);
                  text.push_back(8'($urandom_range(0, 255)));
               end
               8: begin
                  text.push_back(esd_pkg::BACKSLASH_CHAR);
                  text.push_back(esd_pkg::LOWER_X_CHAR);
                  text.push_back(rand_hex_char());
                  text.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  text.push_back(esd_pkg::BACKSLASH_CHAR);   // bare backslash, maybe cut off
               end
            endcase
         end

         if (string_idx == 5) begin
            // receiver goes quiet while the sender keeps pushing back to back
            long_hold_req <= long_hold_req + 1;
            gapless_left = 40;
         end
         if (string_idx == 14) begin
            drain_results();
         end

         foreach (text[i]) begin
            send_item(stim_row(text[i], (i == text.size() - 1), 1'b0, 0));
         end
         string_idx++;
      end

      drain_results();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #1_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
src/esd_pkg.sv
src/esd_chan_if.sv
src/esd_front.sv
src/esd_queue.sv
src/esd_back.sv
src/escape_sequence_decoder_unit.sv
verif/tb_top.sv
